@@ rtl/twodo_pkg.sv @@
// ----------------------------------------------------------------------------
// twodo_pkg
// Shared constants for the tracking-wheel odometry core: fixed-point
// constants, serial unit widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package twodo_pkg;

   localparam int ANGLE_BITS_DEF = 32;

   // serial multiplier: A operand, B operand (one bit per cycle), product
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 64;

   // serial divider: dividend (one quotient bit per cycle), divisor
   localparam int DIV_N_W = 50;
   localparam int DIV_D_W = 14;

   localparam logic [31:0] TWOPI_Q29  = 32'd3373259426;
   localparam logic [33:0] PI_Q32     = 34'd13493037705;
   localparam logic [25:0] INV2PI_Q28 = 26'd42722830;
   localparam logic [30:0] ONE_Q30    = 31'h40000000;

   localparam logic [39:0] TRAVEL_MAX = 40'h7FFFFFFFFF;
   localparam logic [39:0] TRAVEL_MIN = 40'h8000000000;

   localparam logic [DIV_D_W-1:0] DIV_72 = 14'd72;
   localparam logic [DIV_D_W-1:0] DIV_42 = 14'd42;
   localparam logic [DIV_D_W-1:0] DIV_20 = 14'd20;
   localparam logic [DIV_D_W-1:0] DIV_6  = 14'd6;

   // register indexes
   localparam logic [1:0] CSR_INCHES_PER_DEGREE = 2'd0;
   localparam logic [1:0] CSR_TRACK_WIDTH       = 2'd1;
   localparam logic [1:0] CSR_LEFT_WHEEL_OFFSET = 2'd2;

   localparam logic [15:0] IPD_RESET = 16'd1676;
   localparam logic [13:0] TW_RESET  = 14'd3072;
   localparam logic [12:0] LWO_RESET = 13'd1536;

endpackage

@@ rtl/twodo_mul.sv @@
// ----------------------------------------------------------------------------
// twodo_mul
// Unsigned shift-add multiplier, one B bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module twodo_mul #(
   parameter int A_W = twodo_pkg::MUL_A_W,
   parameter int B_W = twodo_pkg::MUL_B_W,
   parameter int P_W = twodo_pkg::MUL_P_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [A_W-1:0] a,
   input  logic [B_W-1:0] b,
   output logic           done,
   output logic [P_W-1:0] p
);

   localparam int CNT_W = $clog2(B_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [A_W-1:0]   a_ff;
   logic [B_W-1:0]   b_ff;
   logic [P_W-1:0]   acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(B_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= a;
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= (acc_ff << 1) + (b_ff[B_W-1] ? P_W'(a_ff) : '0);
         b_ff   <= b_ff << 1;
      end
   end

   assign done = done_ff;
   assign p    = acc_ff;

endmodule

@@ rtl/twodo_div.sv @@
// ----------------------------------------------------------------------------
// twodo_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twodo_div #(
   parameter int N_W = twodo_pkg::DIV_N_W,
   parameter int D_W = twodo_pkg::DIV_D_W
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [N_W-1:0] n,
   input  logic [D_W-1:0] d,
   output logic           done,
   output logic [N_W-1:0] q
);

   localparam int CNT_W = $clog2(N_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [N_W-1:0]   n_ff;
   logic [N_W-1:0]   q_ff;
   logic [D_W-1:0]   d_ff;
   logic [D_W-1:0]   rem_ff;
   logic [D_W:0]     trial;
   logic             fits;

   assign trial = {rem_ff, n_ff[N_W-1]};
   assign fits  = trial >= {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(N_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= n;
         d_ff   <= d;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (busy_ff) begin
         rem_ff <= fits ? D_W'(trial - {1'b0, d_ff}) : trial[D_W-1:0];
         q_ff   <= {q_ff[N_W-2:0], fits};
         n_ff   <= n_ff << 1;
      end
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

@@ rtl/tracking_wheel_odometry_core.sv @@
// ----------------------------------------------------------------------------
// tracking_wheel_odometry_core
// Arc odometry from two absolute tracking-wheel encoder angles.
// ----------------------------------------------------------------------------
// Each request carries one sample of the left and right encoder angles. The
// core turns the count deltas into wheel travel, derives the heading change
// from the wheel difference over track width, and moves the tracking center
// along the arc chord at the mid-turn heading; position saturates at the
// 40-bit limits. One request is processed at a time: a sequencer runs some
// 25 products through a bit-serial multiplier and 13 quotients through a
// bit-serial divider, one unit at a time, before the result is written. A
// finished result sits in the output register while the next request is
// accepted. Configuration writes are always accepted; index 3 is ignored.
// ----------------------------------------------------------------------------
module tracking_wheel_odometry_core #(
   parameter int ANGLE_BITS = twodo_pkg::ANGLE_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request: [31:0] left_count, [63:32] right_count
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,
   // result: [15:0] heading, [31:16] heading_change, [71:32] pos_x,
   //         [111:72] pos_y
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);

   localparam int AB     = ANGLE_BITS;
   localparam int MAG_SH = 60 - AB;
   localparam logic [AB-1:0] MAG_LIM = {1'b0, {(AB-1){1'b1}}};
   localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};
   localparam logic [AB-2:0] QUARTER_R = {1'b1, {(AB-2){1'b0}}};

   typedef enum logic [20:0] {
      S_IDLE = 21'd1,      S_DL = 21'd2,        S_DR = 21'd4,
      S_RAD = 21'd8,       S_MAG = 21'd16,      S_U = 21'd32,
      S_U2 = 21'd64,       S_D72 = 21'd128,     S_T1 = 21'd256,
      S_D42 = 21'd512,     S_T2 = 21'd1024,     S_D20 = 21'd2048,
      S_T3 = 21'd4096,     S_D6 = 21'd8192,     S_SX = 21'd16384,
      S_TERM = 21'd32768,  S_P1 = 21'd65536,    S_SU = 21'd131072,
      S_DX = 21'd262144,   S_DY = 21'd524288,   S_OUT = 21'd1048576
   } state_type;

   // which caller the shared sinc sequence returns to
   typedef enum logic [2:0] {
      PH_CHORD = 3'b001, PH_SIN = 3'b010, PH_COS = 3'b100
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;
   logic      busy_ff;

   // configuration
   logic [15:0] ipd_ff;
   logic [13:0] tw_ff;
   logic [12:0] lwo_ff;

   // odometry state
   logic [31:0]        last_left_ff, last_right_ff;
   logic [AB-1:0]      head_ff;
   logic signed [39:0] x_ff, y_ff;

   // working registers
   logic [31:0]        dlt_l_ff, dlt_r_ff;
   logic signed [39:0] dl_ff, dr_ff;
   logic               neg_ff;
   logic [33:0]        rad_ff;
   logic [AB-1:0]      mag_ff;
   logic [30:0]        u_ff, t_ff, f_ff, sx_ff;
   logic [31:0]        u2_ff, w_ff;
   logic [23:0]        term_ff;
   logic signed [41:0] s_ff;
   logic [30:0]        sin_ff, cos_ff;
   logic               sin_neg_ff, cos_neg_ff;

   logic         rsp_valid_ff;
   logic [111:0] rsp_data_ff;

   // serial units
   logic                          mul_start, div_start, is_mul, unit_done, computing;
   logic [twodo_pkg::MUL_A_W-1:0] mul_a;
   logic [twodo_pkg::MUL_B_W-1:0] mul_b;
   logic [twodo_pkg::MUL_P_W-1:0] mul_p;
   logic                          mul_done;
   logic [twodo_pkg::DIV_N_W-1:0] div_n, div_q;
   logic [twodo_pkg::DIV_D_W-1:0] div_d;
   logic                          div_done;

   twodo_mul u_mul (
      .clock (clock), .reset (reset), .start (mul_start),
      .a (mul_a), .b (mul_b), .done (mul_done), .p (mul_p)
   );

   twodo_div u_div (
      .clock (clock), .reset (reset), .start (div_start),
      .n (div_n), .d (div_d), .done (div_done), .q (div_q)
   );

   // derived values
   logic [31:0]        dabs_l, dabs_r;
   logic signed [40:0] diff;
   logic [40:0]        diff_mag;
   logic [25:0]        m_clamp;
   logic [39:0]        dl_mag;
   logic [40:0]        s_mag;
   logic [AB-1:0]      half, hm, ang, bin;
   logic [1:0]         quad;
   logic [AB-2:0]      a_red;
   logic [63:0]        mag_full;
   logic [30:0]        sq_res;
   logic signed [41:0] p1_s, term_s, s_new;
   logic [41:0]        dm;
   logic signed [42:0] dxs;
   logic signed [43:0] pos_sum;
   logic signed [39:0] pos_sat;
   logic               d_neg;

   always_comb begin
      dabs_l   = dlt_l_ff[31] ? 32'(-dlt_l_ff) : dlt_l_ff;
      dabs_r   = dlt_r_ff[31] ? 32'(-dlt_r_ff) : dlt_r_ff;
      diff     = $signed({dl_ff[39], dl_ff}) - $signed({dr_ff[39], dr_ff});
      diff_mag = diff[40] ? 41'(-diff) : 41'(diff);
      m_clamp  = (diff_mag > 41'h2000000) ? 26'h2000000 : diff_mag[25:0];
      dl_mag   = dl_ff[39] ? 40'(-dl_ff) : 40'(dl_ff);
      s_mag    = s_ff[41] ? 41'(-s_ff) : 41'(s_ff);
      // mid-turn heading and quadrant reduction
      half     = mag_ff >> 1;
      hm       = neg_ff ? head_ff - half : head_ff + half;
      ang      = (phase_ff == PH_COS) ? hm + QUARTER : hm;
      quad     = ang[AB-1:AB-2];
      a_red    = quad[0] ? QUARTER_R - {1'b0, ang[AB-3:0]} : {1'b0, ang[AB-3:0]};
      bin      = neg_ff ? AB'(-mag_ff) : mag_ff;
      mag_full = mul_p >> MAG_SH;
      sq_res   = mul_p[60:30];
      // chord: dl * f - offset term, each with its sign
      p1_s     = dl_ff[39] ? -$signed({2'b00, mul_p[59:20]}) : $signed({2'b00, mul_p[59:20]});
      term_s   = neg_ff ? -$signed({18'd0, term_ff}) : $signed({18'd0, term_ff});
      s_new    = p1_s - term_s;
      // position step along the mid-turn heading
      dm       = mul_p[61:20];
      d_neg    = s_ff[41] ^ ((state_ff == S_DX) ? sin_neg_ff : cos_neg_ff);
      dxs      = d_neg ? -$signed({1'b0, dm}) : $signed({1'b0, dm});
      pos_sum  = $signed({{4{(state_ff == S_DX) ? x_ff[39] : y_ff[39]}},
                          (state_ff == S_DX) ? x_ff : y_ff}) + $signed({dxs[42], dxs});
      if (pos_sum > 44'sd549755813887) begin
         pos_sat = $signed(twodo_pkg::TRAVEL_MAX);
      end else if (pos_sum < -44'sd549755813888) begin
         pos_sat = $signed(twodo_pkg::TRAVEL_MIN);
      end else begin
         pos_sat = pos_sum[39:0];
      end
   end

   // operand selection for the current step
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      div_n  = '0;
      div_d  = twodo_pkg::DIV_6;
      is_mul = 1'b1;
      unique case (state_ff)
         S_DL: begin
            mul_a = 48'(dabs_l);
            mul_b = 32'(ipd_ff);
         end
         S_DR: begin
            mul_a = 48'(dabs_r);
            mul_b = 32'(ipd_ff);
         end
         S_RAD: begin
            is_mul = 1'b0;
            div_n  = {m_clamp, 24'd0};
            div_d  = (tw_ff == '0) ? 14'd1 : tw_ff;
         end
         S_MAG: begin
            mul_a = 48'(rad_ff);
            mul_b = 32'(twodo_pkg::INV2PI_Q28);
         end
         S_U: begin
            mul_a = 48'(twodo_pkg::TWOPI_Q29);
            mul_b = 32'(mag_ff);
         end
         S_SU: begin
            mul_a = 48'(twodo_pkg::TWOPI_Q29);
            mul_b = 32'(a_red);
         end
         S_U2: begin
            mul_a = 48'(u_ff);
            mul_b = 32'(u_ff);
         end
         S_D72: begin
            is_mul = 1'b0;
            div_n  = 50'(u2_ff);
            div_d  = twodo_pkg::DIV_72;
         end
         S_T1, S_T2, S_T3: begin
            mul_a = 48'(u2_ff);
            mul_b = 32'(t_ff);
         end
         S_D42: begin
            is_mul = 1'b0;
            div_n  = 50'(w_ff);
            div_d  = twodo_pkg::DIV_42;
         end
         S_D20: begin
            is_mul = 1'b0;
            div_n  = 50'(w_ff);
            div_d  = twodo_pkg::DIV_20;
         end
         S_D6: begin
            is_mul = 1'b0;
            div_n  = 50'(w_ff);
            div_d  = twodo_pkg::DIV_6;
         end
         S_SX: begin
            mul_a = 48'(u_ff);
            mul_b = 32'(f_ff);
         end
         S_TERM: begin
            mul_a = 48'(lwo_ff);
            mul_b = 32'(sx_ff);
         end
         S_P1: begin
            mul_a = 48'(dl_mag);
            mul_b = 32'(f_ff[30:10]);
         end
         S_DX: begin
            mul_a = 48'(s_mag);
            mul_b = 32'(sin_ff[30:10]);
         end
         S_DY: begin
            mul_a = 48'(s_mag);
            mul_b = 32'(cos_ff[30:10]);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   assign computing = (state_ff != S_IDLE) && (state_ff != S_OUT);
   assign mul_start = computing && !busy_ff && is_mul;
   assign div_start = computing && !busy_ff && !is_mul;
   assign unit_done = is_mul ? mul_done : div_done;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ipd_ff <= twodo_pkg::IPD_RESET;
         tw_ff  <= twodo_pkg::TW_RESET;
         lwo_ff <= twodo_pkg::LWO_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            twodo_pkg::CSR_INCHES_PER_DEGREE: ipd_ff <= csr_data;
            twodo_pkg::CSR_TRACK_WIDTH:       tw_ff  <= csr_data[13:0];
            twodo_pkg::CSR_LEFT_WHEEL_OFFSET: lwo_ff <= csr_data[12:0];
            default: ;
         endcase
      end
   end

   // sequencer and state update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_CHORD;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_left_ff  <= '0;
         last_right_ff <= '0;
         head_ff       <= '0;
         x_ff          <= '0;
         y_ff          <= '0;
      end else begin
         // a new result may replace the one leaving in the same cycle
         if ((state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (mul_start || div_start) begin
            busy_ff <= 1'b1;
         end else if (computing && unit_done) begin
            busy_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  dlt_l_ff      <= req_tdata[31:0] - last_left_ff;
                  dlt_r_ff      <= req_tdata[63:32] - last_right_ff;
                  last_left_ff  <= req_tdata[31:0];
                  last_right_ff <= req_tdata[63:32];
                  state_ff      <= S_DL;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {y_ff, x_ff, bin[AB-1:AB-16], head_ff[AB-1:AB-16]};
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               if (busy_ff && unit_done) begin
                  unique case (state_ff)
                     S_DL: begin
                        if (dlt_l_ff[31]) begin
                           dl_ff <= (mul_p > 64'h8000000000) ?
                                    $signed(twodo_pkg::TRAVEL_MIN) : -$signed(mul_p[39:0]);
                        end else begin
                           dl_ff <= (mul_p > 64'(twodo_pkg::TRAVEL_MAX)) ?
                                    $signed(twodo_pkg::TRAVEL_MAX) : $signed(mul_p[39:0]);
                        end
                        state_ff <= S_DR;
                     end
                     S_DR: begin
                        if (dlt_r_ff[31]) begin
                           dr_ff <= (mul_p > 64'h8000000000) ?
                                    $signed(twodo_pkg::TRAVEL_MIN) : -$signed(mul_p[39:0]);
                        end else begin
                           dr_ff <= (mul_p > 64'(twodo_pkg::TRAVEL_MAX)) ?
                                    $signed(twodo_pkg::TRAVEL_MAX) : $signed(mul_p[39:0]);
                        end
                        state_ff <= S_RAD;
                     end
                     S_RAD: begin
                        neg_ff   <= diff[40];
                        rad_ff   <= (div_q > 50'(twodo_pkg::PI_Q32)) ?
                                    twodo_pkg::PI_Q32 : div_q[33:0];
                        state_ff <= S_MAG;
                     end
                     S_MAG: begin
                        mag_ff   <= (mag_full > 64'(MAG_LIM)) ? MAG_LIM : mag_full[AB-1:0];
                        state_ff <= S_U;
                     end
                     S_U: begin
                        u_ff     <= 31'(mul_p >> AB);
                        phase_ff <= PH_CHORD;
                        state_ff <= S_U2;
                     end
                     S_SU: begin
                        u_ff     <= 31'(mul_p >> (AB - 1));
                        state_ff <= S_U2;
                     end
                     S_U2: begin
                        u2_ff    <= mul_p[61:30];
                        state_ff <= S_D72;
                     end
                     S_D72: begin
                        t_ff     <= twodo_pkg::ONE_Q30 - div_q[30:0];
                        state_ff <= S_T1;
                     end
                     S_T1: begin
                        w_ff     <= mul_p[61:30];
                        state_ff <= S_D42;
                     end
                     S_D42: begin
                        t_ff     <= twodo_pkg::ONE_Q30 - div_q[30:0];
                        state_ff <= S_T2;
                     end
                     S_T2: begin
                        w_ff     <= mul_p[61:30];
                        state_ff <= S_D20;
                     end
                     S_D20: begin
                        t_ff     <= twodo_pkg::ONE_Q30 - div_q[30:0];
                        state_ff <= S_T3;
                     end
                     S_T3: begin
                        w_ff     <= mul_p[61:30];
                        state_ff <= S_D6;
                     end
                     S_D6: begin
                        f_ff     <= twodo_pkg::ONE_Q30 - div_q[30:0];
                        state_ff <= S_SX;
                     end
                     S_SX: begin
                        unique case (phase_ff)
                           PH_CHORD: begin
                              sx_ff    <= sq_res;
                              state_ff <= S_TERM;
                           end
                           PH_SIN: begin
                              sin_ff     <= sq_res;
                              sin_neg_ff <= quad[1];
                              phase_ff   <= PH_COS;
                              state_ff   <= S_SU;
                           end
                           default: begin
                              cos_ff     <= sq_res;
                              cos_neg_ff <= quad[1];
                              state_ff   <= S_DX;
                           end
                        endcase
                     end
                     S_TERM: begin
                        term_ff  <= mul_p[44:21];
                        state_ff <= S_P1;
                     end
                     S_P1: begin
                        s_ff     <= s_new;
                        phase_ff <= PH_SIN;
                        state_ff <= S_SU;
                     end
                     S_DX: begin
                        x_ff     <= pos_sat;
                        state_ff <= S_DY;
                     end
                     S_DY: begin
                        y_ff     <= pos_sat;
                        head_ff  <= head_ff + bin;
                        state_ff <= S_OUT;
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
         endcase
      end
   end

endmodule

@@ bench/odometry_checker.sv @@
// ----------------------------------------------------------------------------
// odometry_checker
// Watches the request, result and register channels of the odometry core,
// predicts each pose update and compares the whole result with it in order.
// ----------------------------------------------------------------------------
module odometry_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [63:0]  req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [111:0] rsp_tdata,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           errors,
   output int           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [63:0] ONE_FIX   = 64'd1 << 30;
   localparam bit [63:0] ANG_MASK  = 64'hFFFF_FFFF;
   localparam bit [63:0] QTR_TURN  = 64'd1 << 30;
   localparam longint    POS_LIMIT = 64'sd549755813887;

   // packed from the top down, so heading lands in the low bits
   typedef struct packed {
      logic signed [39:0] pos_y;
      logic signed [39:0] pos_x;
      logic signed [15:0] heading_change;
      logic [15:0]        heading;
   } pose_type;

   pose_type pending_poses[$];

   logic [15:0] ipd;
   logic [13:0] track_w;
   logic [12:0] lw_offset;
   logic [31:0] prev_left, prev_right;
   bit   [63:0] heading_fix;
   longint      x_fix, y_fix;

   function automatic longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim - 1) return -lim - 1;
      return v;
   endfunction

   // product truncated toward zero on its magnitude
   function automatic longint mul_trunc(longint a, longint b, int sh);
      bit        neg;
      bit [63:0] ma, mb, r;
      neg = (a < 0) != (b < 0);
      ma  = (a < 0) ? -a : a;
      mb  = (b < 0) ? -b : b;
      r   = (ma * mb) >> sh;
      return neg ? -longint'(r) : longint'(r);
   endfunction

   // sin(u)/u, Q30, by the nested series
   function automatic bit [63:0] sinc_fix(bit [63:0] u);
      bit [63:0] u2, t;
      u2 = (u * u) >> 30;
      t  = ONE_FIX - u2 / 72;
      t  = ONE_FIX - ((u2 * t) >> 30) / 42;
      t  = ONE_FIX - ((u2 * t) >> 30) / 20;
      return ONE_FIX - ((u2 * t) >> 30) / 6;
   endfunction

   function automatic longint sine_quarter(bit [63:0] a);
      bit [63:0] u;
      u = (a * 64'(twodo_pkg::TWOPI_Q29)) >> 31;
      return longint'((u * sinc_fix(u)) >> 30);
   endfunction

   function automatic longint sine_of(bit [63:0] h);
      bit [63:0] q, r;
      longint    v;
      h = h & ANG_MASK;
      q = (h >> 30) & 3;
      r = h & (QTR_TURN - 1);
      v = q[0] ? sine_quarter(QTR_TURN - r) : sine_quarter(r);
      return q[1] ? -v : v;
   endfunction

   function automatic longint wheel_travel(logic [31:0] cnt, logic [31:0] prev);
      logic signed [31:0] delta;
      delta = cnt - prev;
      return clamp(longint'(delta) * $signed({48'd0, ipd}), POS_LIMIT);
   endfunction

   function automatic pose_type advance_pose(logic [31:0] lc, logic [31:0] rc);
      pose_type  p;
      longint    dl, dr, diff, bin, term, s, sh, ch;
      bit        neg;
      bit [63:0] m, tw, rad, mag, u, f, sx, half, hm;
      dl = wheel_travel(lc, prev_left);
      dr = wheel_travel(rc, prev_right);
      prev_left  = lc;
      prev_right = rc;
      diff = dl - dr;
      neg  = diff < 0;
      m    = neg ? -diff : diff;
      if (m > (64'd1 << 25)) m = 64'd1 << 25;
      tw   = (track_w != 0) ? 64'(track_w) : 64'd1;
      rad  = (m << 24) / tw;
      if (rad > 64'(twodo_pkg::PI_Q32)) rad = 64'(twodo_pkg::PI_Q32);
      mag  = (rad * 64'(twodo_pkg::INV2PI_Q28)) >> 28;
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      bin  = neg ? -longint'(mag) : longint'(mag);
      // chord from the half turn, minus the wheel offset term
      u    = (mag * 64'(twodo_pkg::TWOPI_Q29)) >> 32;
      f    = sinc_fix(u);
      sx   = (u * f) >> 30;
      term = longint'((64'(lw_offset) * sx) >> 21);
      if (neg) term = -term;
      s    = mul_trunc(dl, longint'(f >> 10), 20) - term;
      half = mag >> 1;
      hm   = (neg ? heading_fix - half : heading_fix + half) & ANG_MASK;
      sh   = sine_of(hm);
      ch   = sine_of(hm + QTR_TURN);
      x_fix = clamp(x_fix + mul_trunc(s, sh / 1024, 20), POS_LIMIT);
      y_fix = clamp(y_fix + mul_trunc(s, ch / 1024, 20), POS_LIMIT);
      heading_fix = (heading_fix + 64'(bin)) & ANG_MASK;
      p.heading        = heading_fix[31:16];
      p.heading_change = bin[31:16];
      p.pos_x          = x_fix[39:0];
      p.pos_y          = y_fix[39:0];
      return p;
   endfunction

   always @(posedge clock) begin
      pose_type got, want;
      if (reset) begin
         ipd         <= twodo_pkg::IPD_RESET;
         track_w     <= twodo_pkg::TW_RESET;
         lw_offset   <= twodo_pkg::LWO_RESET;
         prev_left   <= '0;
         prev_right  <= '0;
         heading_fix <= '0;
         x_fix       <= 0;
         y_fix       <= 0;
         errors      <= 0;
         outstanding <= 0;
         pending_poses.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               twodo_pkg::CSR_INCHES_PER_DEGREE: ipd       <= csr_data;
               twodo_pkg::CSR_TRACK_WIDTH:       track_w   <= csr_data[13:0];
               twodo_pkg::CSR_LEFT_WHEEL_OFFSET: lw_offset <= csr_data[12:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            pending_poses.push_back(advance_pose(req_tdata[31:0], req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (pending_poses.size() == 0) begin
               if (errors < 10) $display("unexpected result %h", rsp_tdata);
               errors <= errors + 1;
            end else begin
               want = pending_poses.pop_front();
               if (got !== want) begin
                  if (errors < 10)
                     $display("mismatch: hdg %h/%h dh %h/%h x %h/%h y %h/%h (exp/act)",
                        want.heading, got.heading, want.heading_change,
                        got.heading_change, want.pos_x, got.pos_x,
                        want.pos_y, got.pos_y);
                  errors <= errors + 1;
               end
            end
         end
         outstanding <= pending_poses.size();
      end
   end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Top of the odometry core bench: drives encoder samples and register
// writes with random gaps and result back-pressure, and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 40000;
   localparam logic [1:0] CSR_UNUSED = 2'd3;  // no register behind it

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;    // [31:0] left_count, [63:32] right_count
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;        // heading, heading_change, pos_x, pos_y
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [15:0]  csr_data = '0;

   int          errors, outstanding;
   int          quiet_cycles = 0;
   bit          no_gaps = 1'b0;     // set for a stretch with no idling
   logic [31:0] left_pos = '0, right_pos = '0;

   always #6 clock = ~clock;

   tracking_wheel_odometry_core u_dut (.*);

   odometry_checker u_chk (.*);

   // result side back-pressure
   always @(posedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= 26);

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_sample(logic [31:0] lc, logic [31:0] rc);
      if (!no_gaps && $urandom_range(99) < 26) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rc, lc};
      left_pos   = lc;
      right_pos  = rc;
      do @(posedge clock); while (!req_tready);
   endtask

   // registers change only once every result is back; outstanding is read only
   // after the checker has counted the last request
   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_geometry(logic [15:0] ipd, logic [15:0] tw, logic [15:0] lwo);
      write_reg(twodo_pkg::CSR_INCHES_PER_DEGREE, ipd);
      write_reg(twodo_pkg::CSR_TRACK_WIDTH, tw);
      write_reg(twodo_pkg::CSR_LEFT_WHEEL_OFFSET, lwo);
   endtask

   // mostly smooth driving: small deltas with a modest left/right split, mixed
   // with hard turns, straight runs and some wild jumps on either encoder
   task automatic drive_random(int n);
      int          kind;
      logic [31:0] dl, dr;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(99);
         dl = $urandom_range(4000) - 2000;
         if (kind < 70)      dr = dl + $urandom_range(200) - 100;
         else if (kind < 85) dr = $urandom_range(4000) - 2000;
         else if (kind < 92) dr = dl;
         else                dr = $urandom;
         if (kind >= 95) dl = $urandom;
         send_sample(left_pos + dl, right_pos + dr);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: straight, gentle turns both ways, encoder wrap, saturation
      send_sample(32'd0, 32'd0);
      send_sample(32'd100, 32'd100);
      send_sample(32'd200, 32'd150);
      send_sample(32'd150, 32'd200);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_sample(32'h8000_0000, 32'h8000_0000);
      send_sample(32'h0000_0000, 32'h8000_0000);
      send_sample(32'hFFFF_FFFB, 32'h7FFF_FFFF);
      send_sample(32'hFFFF_FFFF, 32'h0000_0000);

      set_geometry(16'hFFFF, 16'd256, 16'd8191);
      send_sample(32'h7FFF_FFFF, 32'h8000_0000);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FF00);
      send_sample(32'h7FFF_FF00, 32'h7FFF_FFFF);
      send_sample(32'h0000_0000, 32'h0000_0000);

      set_geometry(16'd1, 16'd16383, 16'd0);
      send_sample(32'd1, 32'd0);
      send_sample(32'hFFFF_FFFF, 32'd1);
      send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // zero track width behaves as one; an unused index is ignored
      write_reg(twodo_pkg::CSR_TRACK_WIDTH, 16'd0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      send_sample(32'd10, 32'd0);
      send_sample(32'd0, 32'd10);
      send_sample(32'd0, 32'd0);

      set_geometry(twodo_pkg::IPD_RESET, 16'(twodo_pkg::TW_RESET),
                   16'(twodo_pkg::LWO_RESET));
      drive_random(300);
      no_gaps = 1'b1;
      drive_random(150);
      no_gaps = 1'b0;
      set_geometry(16'hFFFF, 16'd256, 16'd8191);
      drive_random(200);
      set_geometry(16'd1, 16'd16383, 16'd0);
      drive_random(150);
      for (int k = 0; k < 3; k++) begin
         set_geometry(16'($urandom_range(1, 65535)), 16'($urandom_range(256, 16383)),
                      16'($urandom_range(0, 8191)));
         drive_random(200);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
